// ===== hw/rtl/cwd_pkg.sv =====
// Shared widths and register codes of the wireframe cube distance block.
`default_nettype none
package cwd_pkg;
    localparam int POS_W   = 24;  // signed Q8.16 coordinate
    localparam int CFG_W   = 23;  // unsigned Q7.16 register
    localparam int DIF_W   = 24;  // | |p| - h |
    localparam int SQ_W    = 47;  // square of one axis distance
    localparam int SUM_W   = 48;  // sum of three squares
    localparam int ROOT_W  = 24;  // floor square root of a sum
    localparam int REM_W   = 27;  // square root partial remainder
    localparam int RT_STG  = 8;   // square root pipeline stages
    localparam int RT_STEP = 3;   // root bits resolved per stage
    localparam int LAT     = 4 + RT_STG + 1;

    typedef enum logic [1:0] {
        REG_HALF = 2'd0,
        REG_VRAD = 2'd1,
        REG_ERAD = 2'd2
    } t_reg_idx;
endpackage
`default_nettype wire

// ===== hw/rtl/cube_wireframe_distance.sv =====
// Top level: distance estimate from a point to a wireframe cube.
`default_nettype none
// Usage:
// - Slave stream carries one point per word: tdata = pos_x, pos_y, pos_z,
//   each signed Q8.16, 24 bits, pos_x in the low bits.
// - Master stream returns one word per point: the unsigned Q8.16 distance
//   to the nearer of the vertex spheres and the edge tubes.
// - Configuration: write half_size (0), vertex_radius (1), edge_radius (2)
//   through i_cfg_we / i_cfg_idx / i_cfg_data while the block is empty;
//   other indexes are dropped.
// - Thirteen register stages: two axis stages, a sum stage, a subtract
//   stage, eight square root stages and an output register. Throughput is
//   one point per cycle while the output word is not held by a low
//   m_axis_tready.
// - The whole pipeline moves as one: when the output word waits on a low
//   m_axis_tready, every stage holds and s_axis_tready drops, so nothing
//   is lost or repeated.
// - Synchronous active-low reset clears all valid bits and loads the
//   registers with 1.0, 0.2 and 0.1.
module cube_wireframe_distance
    import cwd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [71:0]       s_axis_tdata,  // pos_x, pos_y, pos_z
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [23:0]            m_axis_tdata   // distance_estimate
);
    logic [CFG_W-1:0]  r_half;
    logic [CFG_W-1:0]  r_vrad;
    logic [CFG_W-1:0]  r_erad;
    logic [LAT-1:0]    r_vld;
    logic              w_adv;
    logic [SQ_W-1:0]   w_sq   [3];
    logic [2:0]        w_in;
    logic [SUM_W-1:0]  r_sv;
    logic [SQ_W-1:0]   r_mm;
    logic [SUM_W-1:0]  r_sv2;
    logic [SUM_W-1:0]  r_se;
    logic [SQ_W-1:0]   w_m [3];
    logic [SQ_W-1:0]   w_m01;
    logic [SQ_W-1:0]   n_mm;
    logic [ROOT_W-1:0] w_rv;
    logic [ROOT_W-1:0] w_re;
    logic [ROOT_W-1:0] w_dv;
    logic [ROOT_W-1:0] w_de;
    logic [ROOT_W-1:0] r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= CFG_W'(65536);
            r_vrad <= CFG_W'(13107);
            r_erad <= CFG_W'(6554);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_HALF: r_half <= i_cfg_data;
                REG_VRAD: r_vrad <= i_cfg_data;
                REG_ERAD: r_erad <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // Advance everything unless the output word is held.
    assign w_adv         = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_ax
        cwd_axis u_axis (
            .i_clk    (i_clk),
            .i_en     (w_adv),
            .i_pos    (s_axis_tdata[a*POS_W +: POS_W]),
            .i_half   (r_half),
            .o_sq     (w_sq[a]),
            .o_inside (w_in[a])
        );
        // An axis whose coordinate lies inside the span can drop its term.
        assign w_m[a] = w_in[a] ? w_sq[a] : '0;
    end

    // The nearest vertex sums the per-axis minima; the nearest edge is the
    // same sum less the largest droppable term.
    always_comb begin
        w_m01 = (w_m[0] > w_m[1]) ? w_m[0] : w_m[1];
        n_mm  = (w_m01 > w_m[2]) ? w_m01 : w_m[2];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sv  <= SUM_W'(w_sq[0]) + SUM_W'(w_sq[1]) + SUM_W'(w_sq[2]);
            r_mm  <= n_mm;
            r_sv2 <= r_sv;
            r_se  <= r_sv - SUM_W'(r_mm);
        end
    end

    cwd_isqrt u_sqrt_v (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_rad  (r_sv2),
        .o_root (w_rv)
    );

    cwd_isqrt u_sqrt_e (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_rad  (r_se),
        .o_root (w_re)
    );

    // Subtract radii, clamp at zero, take the nearer part. A root of a
    // 48-bit value never exceeds the output range.
    always_comb begin
        w_dv = (w_rv > ROOT_W'(r_vrad)) ? w_rv - ROOT_W'(r_vrad) : '0;
        w_de = (w_re > ROOT_W'(r_erad)) ? w_re - ROOT_W'(r_erad) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= (w_dv < w_de) ? w_dv : w_de;
        end
    end

    assign m_axis_tvalid = r_vld[LAT-1];
    assign m_axis_tdata  = r_out;

`ifndef SYNTH
    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_vld[0])
        else $error("accepted word not tracked in first stage");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready disagrees with output stall");

    a_edge_le_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r_se <= r_sv2))
        else $error("edge distance exceeds vertex distance");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/cwd_axis.sv =====
// One axis: distance to the nearer face plane and its square, two stages.
`default_nettype none
module cwd_axis
    import cwd_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic signed [POS_W-1:0] i_pos,
    input  wire logic [CFG_W-1:0]        i_half,
    output logic [SQ_W-1:0]              o_sq,
    output logic                         o_inside
);
    logic signed [POS_W:0] w_pe;
    logic signed [POS_W:0] w_abs;
    logic signed [POS_W:0] w_diff;
    logic [DIF_W-1:0]      n_d;
    logic [DIF_W-1:0]      r_d;
    logic                  r_in1;
    logic [SQ_W-1:0]       r_sq;
    logic                  r_in2;
    logic [2*DIF_W-1:0]    w_prod;

    always_comb begin
        w_pe   = {i_pos[POS_W-1], i_pos};
        w_abs  = w_pe[POS_W] ? -w_pe : w_pe;
        w_diff = w_abs - $signed({2'b00, i_half});
        n_d    = w_diff[POS_W] ? DIF_W'(-w_diff) : DIF_W'(w_diff);
        w_prod = r_d * r_d;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d   <= n_d;
            r_in1 <= w_diff[POS_W];   // strictly inside the edge span
            r_sq  <= w_prod[SQ_W-1:0];
            r_in2 <= r_in1;
        end
    end

    assign o_sq     = r_sq;
    assign o_inside = r_in2;
endmodule
`default_nettype wire

// ===== hw/rtl/cwd_isqrt.sv =====
// Pipelined floor square root, three root bits per stage.
`default_nettype none
module cwd_isqrt
    import cwd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [SUM_W-1:0]  i_rad,
    output logic [ROOT_W-1:0]      o_root
);
    logic [REM_W-1:0]  r_rem  [RT_STG];
    logic [ROOT_W-1:0] r_root [RT_STG];
    logic [SUM_W-1:0]  r_n    [RT_STG];

    for (genvar g = 0; g < RT_STG; g++) begin : g_stg
        logic [REM_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_root_in;
        logic [SUM_W-1:0]  w_n_in;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;
        logic [SUM_W-1:0]  n_n;

        if (g == 0) begin : g_head
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_n_in    = i_rad;
        end else begin : g_body
            assign w_rem_in  = r_rem[g-1];
            assign w_root_in = r_root[g-1];
            assign w_n_in    = r_n[g-1];
        end

        always_comb begin
            logic [REM_W-1:0] rt;
            logic [REM_W-1:0] trial;
            n_rem  = w_rem_in;
            n_root = w_root_in;
            n_n    = w_n_in;
            for (int k = 0; k < RT_STEP; k++) begin
                rt    = {n_rem[REM_W-3:0], n_n[SUM_W-1 -: 2]};
                trial = {1'b0, n_root, 2'b01};
                n_n   = {n_n[SUM_W-3:0], 2'b00};
                if (rt >= trial) begin
                    n_rem  = rt - trial;
                    n_root = {n_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = rt;
                    n_root = {n_root[ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_n[g]    <= n_n;
            end
        end
    end

    assign o_root = r_root[RT_STG-1];
endmodule
`default_nettype wire
